>>> rtl/adsr_pkg.sv
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants for the ADSR envelope applier: phase codes,
// configuration register indexes and sideband widths.
// ----------------------------------------------------------------------------
package adsr_pkg;

    // envelope phase reported with every output word
    typedef enum logic [2:0] {
        PH_ATTACK   = 3'd0,
        PH_DECAY    = 3'd1,
        PH_SUSTAIN  = 3'd2,
        PH_RELEASE  = 3'd3,
        PH_PAST_END = 3'd4
    } phase_t;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ATTACK_SAMPLES  = 3'd0,
        REG_DECAY_SAMPLES   = 3'd1,
        REG_RELEASE_SAMPLES = 3'd2,
        REG_TOTAL_SAMPLES   = 3'd3,
        REG_ATTACK_STEP     = 3'd4,
        REG_DECAY_STEP      = 3'd5,
        REG_RELEASE_STEP    = 3'd6,
        REG_SUSTAIN_GAIN    = 3'd7
    } cfg_index_t;

    // sideband widths
    localparam int IN_TUSER_WIDTH  = 1;
    localparam int OUT_TUSER_WIDTH = 4;

endpackage

>>> rtl/adsr_envelope_applier_core.sv
// ----------------------------------------------------------------------------
// adsr_envelope_applier_core
// Scales a stream of signed samples by a linear attack/decay/sustain/release
// gain held in unsigned fixed point with GAIN_WIDTH-2 fraction bits.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock when the output side is not
// stalled and returns one result word per sample: the word lands in an
// input register, the phase decode, gain multiply, saturation and gain
// update run in one pass, and the result is held in an output register.
// The sample position and running gain are updated as each word leaves the
// input register, so the next word sees them at once and the stream runs at
// one word per cycle while m_tready is high. s_tready follows m_tready when
// both stages are full. Configuration writes are always taken (cfg_ready is
// high) and must only be issued while no words are in flight.
module adsr_envelope_applier_core #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COUNT_WIDTH  = 16,
    parameter int GAIN_WIDTH   = 24,
    localparam int TDATA_WIDTH = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int CFG_WIDTH   = (GAIN_WIDTH > COUNT_WIDTH) ? GAIN_WIDTH : COUNT_WIDTH
) (
    input  logic                                     clk,
    input  logic                                     rst_n,

    // configuration write channel
    input  logic                                     cfg_valid,
    output logic                                     cfg_ready,
    input  logic [adsr_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
    input  logic [CFG_WIDTH-1:0]                     cfg_data,

    // sample input
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [TDATA_WIDTH-1:0]                   s_tdata,   // sample_in
    input  logic [adsr_pkg::IN_TUSER_WIDTH-1:0]      s_tuser,   // note_start

    // result output
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [TDATA_WIDTH-1:0]                   m_tdata,   // sample_out
    output logic [adsr_pkg::OUT_TUSER_WIDTH-1:0]     m_tuser    // phase[2:0], bypass
);

    localparam int GAIN_FRAC = GAIN_WIDTH - 2;
    localparam int PROD_W    = SAMPLE_WIDTH + GAIN_WIDTH + 1;
    localparam int QUOT_W    = SAMPLE_WIDTH + 3;

    localparam logic signed [QUOT_W-1:0] SAT_HI = {4'b0000, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [QUOT_W-1:0] SAT_LO = {4'b1111, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic [GAIN_WIDTH-1:0]    GAIN_MAX  = {GAIN_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0]   COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration registers
    logic [COUNT_WIDTH-1:0] attack_samples_reg;
    logic [COUNT_WIDTH-1:0] decay_samples_reg;
    logic [COUNT_WIDTH-1:0] release_samples_reg;
    logic [COUNT_WIDTH-1:0] total_samples_reg;
    logic [GAIN_WIDTH-1:0]  attack_step_reg;
    logic [GAIN_WIDTH-1:0]  decay_step_reg;
    logic [GAIN_WIDTH-1:0]  release_step_reg;
    logic [GAIN_WIDTH-1:0]  sustain_gain_reg;

    // envelope state
    logic [COUNT_WIDTH-1:0] position_reg, position_next;
    logic [GAIN_WIDTH-1:0]  gain_reg, gain_next;

    // input stage
    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] in_sample_reg;
    logic                           in_note_reg;

    // output stage
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_out_reg, sample_out_next;
    adsr_pkg::phase_t               phase_reg, phase_next;
    logic                           bypass_reg, bypass_next;

    // datapath
    logic                           advance;
    logic [COUNT_WIDTH-1:0]         pos_eff;
    logic [GAIN_WIDTH-1:0]          gain_eff;
    logic [COUNT_WIDTH+1:0]         sum_adr;
    logic [COUNT_WIDTH:0]           sum_ad;
    logic [COUNT_WIDTH:0]           pos_plus_rel;
    logic                           release_start;
    logic [GAIN_WIDTH-1:0]          gain_rel;
    logic [GAIN_WIDTH-1:0]          gain_scale;
    logic [GAIN_WIDTH:0]            gain_add;
    logic [GAIN_WIDTH-1:0]          gain_attack;
    logic [GAIN_WIDTH-1:0]          gain_decay;
    logic [GAIN_WIDTH-1:0]          gain_release;
    logic signed [PROD_W-1:0]       product;
    logic signed [QUOT_W-1:0]       quotient;
    logic signed [SAMPLE_WIDTH-1:0] scaled;

    assign cfg_ready = 1'b1;

    // configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_samples_reg  <= '0;
            decay_samples_reg   <= '0;
            release_samples_reg <= '0;
            total_samples_reg   <= '0;
            attack_step_reg     <= '0;
            decay_step_reg      <= '0;
            release_step_reg    <= '0;
            sustain_gain_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (adsr_pkg::cfg_index_t'(cfg_index))
                adsr_pkg::REG_ATTACK_SAMPLES:  attack_samples_reg  <= cfg_data[COUNT_WIDTH-1:0];
                adsr_pkg::REG_DECAY_SAMPLES:   decay_samples_reg   <= cfg_data[COUNT_WIDTH-1:0];
                adsr_pkg::REG_RELEASE_SAMPLES: release_samples_reg <= cfg_data[COUNT_WIDTH-1:0];
                adsr_pkg::REG_TOTAL_SAMPLES:   total_samples_reg   <= cfg_data[COUNT_WIDTH-1:0];
                adsr_pkg::REG_ATTACK_STEP:     attack_step_reg     <= cfg_data[GAIN_WIDTH-1:0];
                adsr_pkg::REG_DECAY_STEP:      decay_step_reg      <= cfg_data[GAIN_WIDTH-1:0];
                adsr_pkg::REG_RELEASE_STEP:    release_step_reg    <= cfg_data[GAIN_WIDTH-1:0];
                adsr_pkg::REG_SUSTAIN_GAIN:    sustain_gain_reg    <= cfg_data[GAIN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // handshake: input stage moves on when the output stage is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_sample_reg <= $signed(s_tdata[SAMPLE_WIDTH-1:0]);
            in_note_reg   <= s_tuser[0];
        end
    end

    // note start clears position and gain ahead of this word
    assign pos_eff  = in_note_reg ? '0 : position_reg;
    assign gain_eff = in_note_reg ? '0 : gain_reg;

    // phase boundaries
    assign sum_adr      = {2'b00, attack_samples_reg} + {2'b00, decay_samples_reg}
                        + {2'b00, release_samples_reg};
    assign sum_ad       = {1'b0, attack_samples_reg} + {1'b0, decay_samples_reg};
    assign pos_plus_rel = {1'b0, pos_eff} + {1'b0, release_samples_reg};
    assign bypass_next  = sum_adr > {2'b00, total_samples_reg};

    always_comb
    begin
        if (pos_eff >= total_samples_reg)
            phase_next = adsr_pkg::PH_PAST_END;
        else if (pos_eff < attack_samples_reg)
            phase_next = adsr_pkg::PH_ATTACK;
        else if ({1'b0, pos_eff} < sum_ad)
            phase_next = adsr_pkg::PH_DECAY;
        else if (pos_plus_rel >= {1'b0, total_samples_reg})
            phase_next = adsr_pkg::PH_RELEASE;
        else
            phase_next = adsr_pkg::PH_SUSTAIN;
    end

    // saturating gain steps
    assign release_start = pos_plus_rel == {1'b0, total_samples_reg};
    assign gain_rel      = !release_start ? gain_eff :
                           (gain_eff > release_step_reg) ? gain_eff - release_step_reg : '0;
    assign gain_add      = {1'b0, gain_eff} + {1'b0, attack_step_reg};
    assign gain_attack   = gain_add[GAIN_WIDTH] ? GAIN_MAX : gain_add[GAIN_WIDTH-1:0];
    assign gain_decay    = (gain_eff > decay_step_reg) ? gain_eff - decay_step_reg : '0;
    assign gain_release  = (gain_rel > release_step_reg) ? gain_rel - release_step_reg : '0;

    // gain used for this word
    always_comb
    begin
        case (phase_next)
            adsr_pkg::PH_SUSTAIN: gain_scale = sustain_gain_reg;
            adsr_pkg::PH_RELEASE: gain_scale = gain_rel;
            default:              gain_scale = gain_eff;
        endcase
    end

    // multiply, floor shift, saturate
    assign product  = in_sample_reg * $signed({1'b0, gain_scale});
    assign quotient = $signed(product[PROD_W-1:GAIN_FRAC]);
    assign scaled   = (quotient > SAT_HI) ? SAT_HI[SAMPLE_WIDTH-1:0] :
                      (quotient < SAT_LO) ? SAT_LO[SAMPLE_WIDTH-1:0] :
                      quotient[SAMPLE_WIDTH-1:0];

    // result and next gain per phase
    always_comb
    begin
        gain_next       = gain_eff;
        sample_out_next = '0;
        if (bypass_next)
        begin
            sample_out_next = in_sample_reg;
        end
        else
        begin
            unique case (phase_next)
                adsr_pkg::PH_ATTACK:
                begin
                    sample_out_next = scaled;
                    gain_next       = gain_attack;
                end
                adsr_pkg::PH_DECAY:
                begin
                    sample_out_next = scaled;
                    gain_next       = gain_decay;
                end
                adsr_pkg::PH_SUSTAIN:
                begin
                    sample_out_next = scaled;
                end
                adsr_pkg::PH_RELEASE:
                begin
                    sample_out_next = scaled;
                    gain_next       = gain_release;
                end
                default:
                begin
                    sample_out_next = '0;
                end
            endcase
        end
    end

    // position advances and sticks at its top value
    assign position_next = (pos_eff != COUNT_MAX) ? pos_eff + 1'b1 : pos_eff;

    // envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            gain_reg     <= '0;
        end
        else if (advance)
        begin
            position_reg <= position_next;
            gain_reg     <= gain_next;
        end
    end

    // output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_out_reg <= sample_out_next;
            phase_reg      <= phase_next;
            bypass_reg     <= bypass_next;
        end
    end

    // output word packing
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata                    = '0;
        m_tdata[SAMPLE_WIDTH-1:0]  = sample_out_reg;
    end

    assign m_tuser = {bypass_reg, phase_reg};

    // a held input word never sees a ready input
    a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !s_tready)
        else $error("input accepted while input stage is stalled");

    // note start restarts the count
    a_note_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_note_reg) |=> (position_reg == {{(COUNT_WIDTH-1){1'b0}}, 1'b1}))
        else $error("position not restarted by note start");

    // sustain, past-end and bypass hold the running gain
    a_gain_held: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (bypass_next || phase_next == adsr_pkg::PH_SUSTAIN
                     || phase_next == adsr_pkg::PH_PAST_END))
        |=> (gain_reg == $past(gain_eff)))
        else $error("running gain changed outside attack, decay or release");

    // words past the end of the note are silent unless bypassed
    a_past_end_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && phase_reg == adsr_pkg::PH_PAST_END && !bypass_reg)
        |-> (sample_out_reg == '0))
        else $error("nonzero sample past end of note");

endmodule
